// ===== hdl/edfs_pkg.sv =====
// Package for the ellipsoid density field sampler.
// Holds widths, register indexes and the table entry type; no dependencies.
`default_nettype none
package edfs_pkg;
   localparam int VAL_W = 32;
   localparam int RAD_W = 31;

   typedef enum logic [2:0] {
      REG_ENTRY_COUNT   = 3'd0,
      REG_DEFAULT_VALUE = 3'd1,
      REG_FLOOR_ENABLE  = 3'd2,
      REG_FLOOR_Y       = 3'd3,
      REG_FLOOR_VALUE   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] cx;
      logic signed [VAL_W-1:0] cy;
      logic signed [VAL_W-1:0] cz;
      logic [RAD_W-1:0]        ra;
      logic [RAD_W-1:0]        rb;
      logic [RAD_W-1:0]        rc;
      logic signed [VAL_W-1:0] lo;
      logic signed [VAL_W-1:0] hi;
   } entry_type;
endpackage
`default_nettype wire

// ===== hdl/edfs_div.sv =====
// Restoring divider: unsigned quotient of a WN-bit numerator by a WD-bit divisor.
// One quotient bit per cycle. Depends on nothing.
`default_nettype none
module edfs_div #(
   parameter int WN = 64,
   parameter int WD = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          go,
   input  wire logic [WN-1:0] num,
   input  wire logic [WD-1:0] den,
   output logic              done,
   output logic [WN-1:0]     quo
);
   localparam int CW = $clog2(WN + 1);
   logic [WD:0]   rem_ff, rem_in;
   logic [WN-1:0] q_ff, q_in;
   logic [WD-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [WD+1:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[WN-1]} - {2'b00, d_ff};
      if (go) begin
         rem_in  = '0;
         q_in    = num;
         d_in    = den;
         cnt_in  = CW'(WN);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one numerator bit, subtract when it fits
         if (!trial[WD+1]) begin
            rem_in = trial[WD:0];
            q_in   = {q_ff[WN-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WD-1:0], q_ff[WN-1]};
            q_in   = {q_ff[WN-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule
`default_nettype wire

// ===== hdl/edfs_sqrt.sv =====
// Bit-serial integer square root of a 63-bit value, two radicand bits per cycle.
// Depends on nothing.
`default_nettype none
module edfs_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [62:0] val,
   output logic             done,
   output logic [31:0]      root
);
   logic [63:0] v_ff, v_in, r_ff, r_in, b_ff, b_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] t;

   always_comb begin
      v_in = v_ff; r_in = r_ff; b_in = b_ff;
      busy_in = busy_ff; done_in = 1'b0;
      t = r_ff + b_ff;
      if (go) begin
         v_in = {1'b0, val}; r_in = '0; b_in = 64'd1 << 62; busy_in = 1'b1;
      end else if (busy_ff) begin
         // one result bit per step
         if (v_ff >= t) begin
            v_in = v_ff - t;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         if (b_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in; r_ff <= r_in; b_ff <= b_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = r_ff[31:0];
endmodule
`default_nettype wire

// ===== hdl/ellipsoid_density_field_sampler_unit.sv =====
// Ellipsoid density field sampler top level.
// Depends on edfs_pkg, edfs_div and edfs_sqrt.
//
// Usage: drive req_* with start high while busy is low. A load item
// (req_mode 0) writes one entry of the table memory at its transfer edge;
// busy stays low, so the next item may follow without a wait.
// A sample item (req_mode 1) walks entries 0..entry_count-1 (at most
// MAX_ENTRIES) one after the other. Per entry: one memory read, then per
// axis a division on the shared divider and a square, then a square
// root and a lerp multiply; an entry is left early when x, y or z
// already misses or the sum is above one. A sample ends with the
// default value when nothing is hit, or with a mean division otherwise.
// The result appears on rsp_* with rsp_valid for one cycle, in the
// cycle in which busy drops, and the receiver cannot stall it.
// Configuration is to be written over csr_* while the block is idle,
// which the block itself does not enforce; csr_ready is always high.
// Reset clears the configuration registers and the controller; the table
// memory keeps its contents until written.
`default_nettype none
module ellipsoid_density_field_sampler_unit #(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_mode,
   input  wire logic [3:0]  req_entry_index,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic [30:0] req_radius_a,
   input  wire logic [30:0] req_radius_b,
   input  wire logic [30:0] req_radius_c,
   input  wire logic signed [31:0] req_low_value,
   input  wire logic signed [31:0] req_high_value,
   output logic             rsp_valid,
   output logic signed [31:0] rsp_field_value,
   output logic [4:0]       rsp_hit_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import edfs_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int NW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_AXIS, S_DIVW, S_SQR, S_SUM, S_SQRW,
      S_LMUL, S_LACC, S_NEXT, S_MEAN, S_MEANW, S_OUT
   } state_type;

   // configuration registers
   logic [4:0]  cnt_ff;
   logic signed [31:0] dflt_ff, fy_ff, fv_ff;
   logic        fen_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; dflt_ff <= '0; fen_ff <= 1'b0; fy_ff <= '0; fv_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ENTRY_COUNT:   cnt_ff  <= csr_data[4:0];
            REG_DEFAULT_VALUE: dflt_ff <= csr_data;
            REG_FLOOR_ENABLE:  fen_ff  <= csr_data[0];
            REG_FLOOR_Y:       fy_ff   <= csr_data;
            REG_FLOOR_VALUE:   fv_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // table memory, one word per entry
   entry_type mem [MAX_ENTRIES];
   entry_type rd_ff;
   logic [AW-1:0] raddr;
   logic wr_en;
   entry_type wr_data;

   assign wr_data = '{req_pos_x, req_pos_y, req_pos_z, req_radius_a, req_radius_b,
                      req_radius_c, req_low_value, req_high_value};
   assign wr_en = start && !busy && !req_mode &&
                  (int'(req_entry_index) < MAX_ENTRIES);

   always_ff @(posedge clock) begin
      if (wr_en) mem[AW'(req_entry_index)] <= wr_data;
      rd_ff <= mem[raddr];
   end

   // controller state
   state_type st_ff;
   logic [NW-1:0] idx_ff, n_ff, hits_ff;
   logic [1:0]  ax_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [63:0] sq_ff;
   logic [63:0] sum_ff;
   logic        out_ff;      // some axis outside
   logic [31:0] s_ff;
   logic [63:0] prod_ff;
   logic signed [32:0] dif_ff;
   logic signed [39:0] acc_ff;
   logic signed [31:0] res_ff;
   logic        rv_ff;
   logic [4:0]  rh_ff;

   assign raddr = idx_ff[AW-1:0];
   assign busy  = (st_ff != S_IDLE);

   // axis selection
   logic signed [31:0] csel, psel;
   logic [30:0] rsel;
   logic signed [32:0] dd;
   logic [32:0] ad;
   always_comb begin
      case (ax_ff)
         2'd0: begin csel = rd_ff.cx; psel = px_ff; rsel = rd_ff.ra; end
         2'd1: begin csel = rd_ff.cy; psel = py_ff; rsel = rd_ff.rb; end
         default: begin csel = rd_ff.cz; psel = pz_ff; rsel = rd_ff.rc; end
      endcase
      dd = 33'(csel) - 33'(psel);
      ad = dd[32] ? 33'(-dd) : 33'(dd);
   end

   // shared divider
   logic        dgo, ddone;
   logic [63:0] dnum, dquo;
   logic [31:0] dden;
   edfs_div #(.WN(64), .WD(32)) u_div (
      .clock(clock), .reset(reset), .go(dgo), .num(dnum), .den(dden),
      .done(ddone), .quo(dquo)
   );

   logic        sgo, sdone;
   logic [31:0] sroot;
   edfs_sqrt u_sqrt (
      .clock(clock), .reset(reset), .go(sgo), .val(sum_ff[62:0]),
      .done(sdone), .root(sroot)
   );

   logic [39:0] accmag;
   assign accmag = acc_ff[39] ? 40'(-acc_ff) : 40'(acc_ff);
   logic [32:0] dmag;
   assign dmag = dif_ff[32] ? 33'(-dif_ff) : 33'(dif_ff);

   always_comb begin
      dgo = 1'b0; dnum = '0; dden = '0; sgo = 1'b0;
      if (st_ff == S_AXIS && !(rsel == '0 || ad > {2'b00, rsel})) begin
         dgo = 1'b1; dden = {1'b0, rsel};
         dnum = 64'(ad) << 31;
      end
      if (st_ff == S_MEAN && hits_ff != '0) begin
         dgo = 1'b1; dnum = 64'(accmag); dden = 32'(hits_ff);
      end
      if (st_ff == S_SUM && !out_ff && sum_ff <= (64'd1 << 62)) sgo = 1'b1;
   end

   logic signed [31:0] mean;
   assign mean = acc_ff[39] ? -$signed(dquo[31:0]) : $signed(dquo[31:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rv_ff <= 1'b0; idx_ff <= '0; hits_ff <= '0;
      end else begin
         rv_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (start && req_mode) begin
               px_ff <= req_pos_x; py_ff <= req_pos_y; pz_ff <= req_pos_z;
               idx_ff <= '0; hits_ff <= '0; acc_ff <= '0;
               n_ff <= (int'(cnt_ff) > MAX_ENTRIES) ? NW'(MAX_ENTRIES) : NW'(cnt_ff);
               st_ff <= S_NEXT;
            end
            S_NEXT: st_ff <= (idx_ff < n_ff) ? S_READ : S_MEAN;
            S_READ: begin ax_ff <= 2'd0; out_ff <= 1'b0; sum_ff <= '0;
               st_ff <= S_AXIS; end
            S_AXIS: begin
               if (rsel == '0 || ad > {2'b00, rsel}) begin
                  out_ff <= 1'b1; st_ff <= S_SUM;
               end else st_ff <= S_DIVW;
            end
            S_DIVW: if (ddone) begin
               sq_ff <= 64'(dquo[31:0]) * 64'(dquo[31:0]);
               st_ff <= S_SQR;
            end
            S_SQR: begin
               sum_ff <= sum_ff + sq_ff;
               if (ax_ff == 2'd2) st_ff <= S_SUM;
               else begin ax_ff <= ax_ff + 2'd1; st_ff <= S_AXIS; end
            end
            S_SUM: begin
               if (sgo) st_ff <= S_SQRW;
               else begin idx_ff <= idx_ff + 1'b1; st_ff <= S_NEXT; end
               dif_ff <= 33'(rd_ff.hi) - 33'(rd_ff.lo);
            end
            S_SQRW: if (sdone) begin s_ff <= sroot; st_ff <= S_LMUL; end
            S_LMUL: begin
               prod_ff <= 64'(dmag) * 64'(s_ff);
               st_ff <= S_LACC;
            end
            S_LACC: begin
               if (!dif_ff[32])
                  acc_ff <= acc_ff + 40'(rd_ff.lo) + 40'(prod_ff >> 31);
               else
                  acc_ff <= acc_ff + 40'(rd_ff.lo)
                            - 40'((prod_ff + 64'h7FFF_FFFF) >> 31);
               hits_ff <= hits_ff + 1'b1;
               idx_ff <= idx_ff + 1'b1;
               st_ff <= S_NEXT;
            end
            S_MEAN: begin
               if (hits_ff == '0) begin res_ff <= dflt_ff; st_ff <= S_OUT; end
               else st_ff <= S_MEANW;
            end
            S_MEANW: if (ddone) begin res_ff <= mean; st_ff <= S_OUT; end
            S_OUT: begin
               rv_ff <= 1'b1;
               rh_ff <= 5'(hits_ff);
               res_ff <= (fen_ff && py_ff < fy_ff) ? fv_ff : res_ff;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_field_value = res_ff;
   assign rsp_hit_count   = rh_ff;

   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= idx_ff) else $error("hit count exceeds visited entries");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> st_ff == S_IDLE) else $error("result while busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
endmodule
`default_nettype wire
